// ===== rtl/sbb_pkg.sv =====
// Shared types and constants for the separable box blur.
`default_nettype none

package sbb_pkg;

  localparam int ARGB_W   = 32;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 16;
  localparam int RADIUS_W = 5;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Register word indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } reg_idx_t;

  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [RADIUS_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic              drain;
    logic [ARGB_W-1:0] argb;
  } item_t;

  typedef struct packed {
    logic [ARGB_W-1:0] argb;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sbb_queue.sv =====
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
`default_nettype none

module sbb_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_func,
  input  wire logic [sbb_pkg::ARGB_W-1:0] in_argb,
  output logic                            q_valid,
  output sbb_pkg::item_t                  q_item,
  input  wire logic                       q_pop
);
  import sbb_pkg::*;

  localparam int QDEPTH = 2;

  item_t       ent_r [QDEPTH];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;
  item_t       new_item;

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    new_item.drain = (in_func == FUNC_DRAIN);
    new_item.argb  = in_argb;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbb_div.sv =====
// Iterative divider: four byte lanes by one shared count, one quotient bit per cycle.
`default_nettype none

module sbb_div #(
  parameter int CW = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [CW-1:0]        cnt,
  input  wire logic [3:0][CW+7:0]   sum,
  output logic                      done,
  output logic [31:0]               quo
);
  import sbb_pkg::*;

  localparam int QW = CW + 8;

  logic [3:0][QW-1:0] rem_r, rem_nxt;
  logic [QW-1:0]      den_r, den_nxt;
  logic [3:0][7:0]    q_r, q_nxt;
  logic [2:0]         step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  assign done = done_r;
  assign quo  = q_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = sum;
      den_nxt  = QW'({cnt, 7'b0});
      step_nxt = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The quotient never exceeds a byte, so eight restoring steps suffice.
      for (int c = 0; c < 4; c++) begin
        if (rem_r[c] >= den_r) begin
          rem_nxt[c] = rem_r[c] - den_r;
          q_nxt[c]   = {q_r[c][6:0], 1'b1};
        end else begin
          q_nxt[c]   = {q_r[c][6:0], 1'b0};
        end
      end
      den_nxt  = den_r >> 1;
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sbb_engine.sv =====
// Back end: row store, horizontal pass, line ring and vertical pass of the blur.
`default_nettype none

module sbb_engine #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  sbb_pkg::cfg_t  cfg,
  input  wire logic   q_valid,
  input  sbb_pkg::item_t q_item,
  output logic        q_pop,
  output logic        res_valid,
  output sbb_pkg::res_t res,
  input  wire logic   res_take
);
  import sbb_pkg::*;

  localparam int CLW  = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int RING = 2 * MAX_RADIUS;
  localparam int SLW  = $clog2(RING);
  localparam int CW   = $clog2(2 * MAX_RADIUS + 1);
  localparam int SW   = CW + 8;
  localparam int XW   = ((WW > RW) ? WW : RW) + 1;
  localparam int SXW  = ((SLW > RW) ? SLW : RW) + 1;
  localparam int YW   = HEIGHT_W + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HLOAD = 10'b0000000010,
    S_HDIV  = 10'b0000000100,
    S_HWAIT = 10'b0000001000,
    S_HFIN  = 10'b0000010000,
    S_CHECK = 10'b0000100000,
    S_VLOAD = 10'b0001000000,
    S_VDIV  = 10'b0010000000,
    S_VWAIT = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    logic [SLW-1:0] n;
    if (s == SLW'(RING - 1)) n = '0;
    else                     n = s + SLW'(1);
    return n;
  endfunction

  state_t             state_r, state_nxt;
  logic [CLW-1:0]     in_col_r, in_col_nxt;
  logic [HEIGHT_W-1:0] in_row_r, in_row_nxt;
  logic [CLW-1:0]     out_col_r, out_col_nxt;
  logic [HEIGHT_W-1:0] out_row_r, out_row_nxt;
  logic [SLW-1:0]     wr_slot_r, wr_slot_nxt;
  logic [SLW-1:0]     in_base_r, in_base_nxt;
  logic [SLW-1:0]     row_slot_r, row_slot_nxt;
  logic               in_ahead_r, in_ahead_nxt;
  logic [CLW-1:0]     hj_r, hj_nxt;
  logic [RW-1:0]      lk_r, lk_nxt;
  logic [CW-1:0]      vk_r, vk_nxt;
  logic [CW-1:0]      vcnt_r, vcnt_nxt;
  logic [SLW-1:0]     vslot_r, vslot_nxt;
  logic [3:0][SW-1:0] sum_r, sum_nxt, sum_acc;
  logic               acc_a_r, acc_a_nxt;
  logic               acc_b_r, acc_b_nxt;
  logic               acc_v_r, acc_v_nxt;
  logic [ARGB_W-1:0]  res_argb_r, res_argb_nxt;
  logic               res_last_r, res_last_nxt;

  logic [WW-1:0]      w_eff;
  logic [RW-1:0]      r_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic [ARGB_W-1:0]  row_mem [MAX_WIDTH];
  logic [ARGB_W-1:0]  hb_mem  [RING][MAX_WIDTH];
  logic [ARGB_W-1:0]  ra_q, rb_q, hq;
  logic [CLW-1:0]     ra_addr, rb_addr;
  logic               row_we, hb_we;

  logic               div_start, div_done;
  logic [CW-1:0]      div_cnt;
  logic [31:0]        div_quo;

  // Horizontal window of the current column.
  logic [XW-1:0] jx, rx, wx, jr, hi_h, lo_h, ln;
  logic [CW-1:0] hcnt;
  logic          add_ok, sub_ok, last_j;

  // Vertical window of the current output.
  logic [RW-1:0]  sub_v;
  logic [YW-1:0]  lo_v, hi_v;
  logic           v_has, rdy, last_c;
  logic [CW-1:0]  vcnt_c;
  logic [SXW-1:0] sa, sb;
  logic [SLW-1:0] vs0;

  logic [WW-1:0]  ic1, oc1;
  logic [YW-1:0]  ir1, or1;

  always_comb begin
    if (cfg.width == '0)                          w_eff = WW'(1);
    else if (32'(cfg.width) > 32'(MAX_WIDTH))     w_eff = WW'(MAX_WIDTH);
    else                                          w_eff = WW'(cfg.width);
    if (cfg.radius == '0)                         r_eff = RW'(1);
    else if (32'(cfg.radius) > 32'(MAX_RADIUS))   r_eff = RW'(MAX_RADIUS);
    else                                          r_eff = RW'(cfg.radius);
    h_eff = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
  end

  always_comb begin
    jx     = XW'(hj_r);
    rx     = XW'(r_eff);
    wx     = XW'(w_eff);
    jr     = jx + rx;
    add_ok = (jr < wx);
    sub_ok = (jx >= rx);
    hi_h   = add_ok ? jr : wx;
    lo_h   = (jx > rx) ? (jx - rx) : '0;
    hcnt   = CW'(hi_h - lo_h);
    ln     = (rx < wx) ? rx : wx;
    last_j = ((jx + XW'(1)) >= wx);

    sub_v  = (YW'(out_row_r) > YW'(r_eff)) ? r_eff : RW'(out_row_r);
    lo_v   = YW'(out_row_r) - YW'(sub_v);
    hi_v   = ((YW'(out_row_r) + YW'(r_eff)) < YW'(h_eff)) ?
             (YW'(out_row_r) + YW'(r_eff)) : YW'(h_eff);
    v_has  = (hi_v > lo_v);
    vcnt_c = CW'(hi_v - lo_v);
    rdy    = in_ahead_r || (YW'(in_row_r) >= hi_v);
    last_c = ((YW'(out_row_r) + YW'(1)) == YW'(h_eff)) &&
             ((WW'(out_col_r) + WW'(1)) == w_eff);

    sa  = SXW'(row_slot_r);
    sb  = SXW'(sub_v);
    vs0 = (sa >= sb) ? SLW'(sa - sb) : SLW'(sa + SXW'(RING) - sb);

    ic1 = WW'(in_col_r) + WW'(1);
    oc1 = WW'(out_col_r) + WW'(1);
    ir1 = YW'(in_row_r) + YW'(1);
    or1 = YW'(out_row_r) + YW'(1);
  end

  always_comb begin
    logic [SW-1:0] s;
    for (int c = 0; c < 4; c++) begin
      s = sum_r[c];
      if (acc_a_r) s = s + SW'(ra_q[8*c +: 8]);
      if (acc_b_r) s = s - SW'(rb_q[8*c +: 8]);
      if (acc_v_r) s = s + SW'(hq[8*c +: 8]);
      sum_acc[c] = s;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    wr_slot_nxt  = wr_slot_r;
    in_base_nxt  = in_base_r;
    row_slot_nxt = row_slot_r;
    in_ahead_nxt = in_ahead_r;
    hj_nxt       = hj_r;
    lk_nxt       = lk_r;
    vk_nxt       = vk_r;
    vcnt_nxt     = vcnt_r;
    vslot_nxt    = vslot_r;
    sum_nxt      = sum_acc;
    acc_a_nxt    = 1'b0;
    acc_b_nxt    = 1'b0;
    acc_v_nxt    = 1'b0;
    res_argb_nxt = res_argb_r;
    res_last_nxt = res_last_r;
    ra_addr      = '0;
    rb_addr      = '0;
    row_we       = 1'b0;
    hb_we        = 1'b0;
    div_start    = 1'b0;
    div_cnt      = vcnt_r;
    q_pop        = 1'b0;

    case (state_r)
      S_IDLE: begin
        q_pop = 1'b1;
        if (q_valid) begin
          if (q_item.drain) begin
            state_nxt = S_CHECK;
          end else begin
            row_we = 1'b1;
            if (ic1 >= w_eff) begin
              in_col_nxt = '0;
              hj_nxt     = '0;
              lk_nxt     = '0;
              sum_nxt    = '0;
              state_nxt  = S_HLOAD;
            end else begin
              in_col_nxt = CLW'(ic1);
              state_nxt  = S_CHECK;
            end
          end
        end
      end
      S_HLOAD: begin
        // Prime the window sum of column zero.
        ra_addr = CLW'(lk_r);
        if (XW'(lk_r) != ln) begin
          acc_a_nxt = 1'b1;
          lk_nxt    = lk_r + RW'(1);
        end else if (!acc_a_r) begin
          state_nxt = S_HDIV;
        end
      end
      S_HDIV: begin
        // Divide this column while the window slides to the next one.
        div_start = 1'b1;
        div_cnt   = hcnt;
        ra_addr   = CLW'(jr);
        rb_addr   = CLW'(jx - rx);
        acc_a_nxt = add_ok;
        acc_b_nxt = sub_ok;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        if (div_done) begin
          hb_we = 1'b1;
          if (last_j) begin
            state_nxt = S_HFIN;
          end else begin
            hj_nxt    = hj_r + CLW'(1);
            state_nxt = S_HDIV;
          end
        end
      end
      S_HFIN: begin
        wr_slot_nxt = slot_inc(wr_slot_r);
        if (ir1 >= YW'(h_eff)) begin
          in_row_nxt   = '0;
          in_ahead_nxt = 1'b1;
          in_base_nxt  = slot_inc(wr_slot_r);
        end else begin
          in_row_nxt = HEIGHT_W'(ir1);
        end
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!rdy) begin
          state_nxt = S_IDLE;
        end else begin
          res_last_nxt = last_c;
          if (v_has) begin
            sum_nxt   = '0;
            vk_nxt    = '0;
            vcnt_nxt  = vcnt_c;
            vslot_nxt = vs0;
            state_nxt = S_VLOAD;
          end else begin
            res_argb_nxt = '0;
            state_nxt    = S_EMIT;
          end
        end
      end
      S_VLOAD: begin
        if (vk_r != vcnt_r) begin
          acc_v_nxt = 1'b1;
          vk_nxt    = vk_r + CW'(1);
          vslot_nxt = slot_inc(vslot_r);
        end else if (!acc_v_r) begin
          state_nxt = S_VDIV;
        end
      end
      S_VDIV: begin
        div_start = 1'b1;
        state_nxt = S_VWAIT;
      end
      S_VWAIT: begin
        if (div_done) begin
          res_argb_nxt = div_quo;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_take) begin
          if (oc1 >= w_eff) begin
            out_col_nxt = '0;
            if (or1 >= YW'(h_eff)) begin
              out_row_nxt  = '0;
              row_slot_nxt = in_base_r;
              in_ahead_nxt = 1'b0;
            end else begin
              out_row_nxt  = HEIGHT_W'(or1);
              row_slot_nxt = slot_inc(row_slot_r);
            end
          end else begin
            out_col_nxt = CLW'(oc1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_valid = (state_r == S_EMIT);
  assign res.argb  = res_argb_r;
  assign res.last  = res_last_r;

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[in_col_r] <= q_item.argb;
    end
    ra_q <= row_mem[ra_addr];
    rb_q <= row_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (hb_we) begin
      hb_mem[wr_slot_r][hj_r] <= div_quo;
    end
    hq <= hb_mem[vslot_r][out_col_r];
  end

  sbb_div #(.CW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .cnt   (div_cnt),
    .sum   (sum_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    vcnt_r     <= vcnt_nxt;
    vslot_r    <= vslot_nxt;
    res_argb_r <= res_argb_nxt;
    res_last_r <= res_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      wr_slot_r  <= '0;
      in_base_r  <= '0;
      row_slot_r <= '0;
      in_ahead_r <= 1'b0;
      hj_r       <= '0;
      lk_r       <= '0;
      vk_r       <= '0;
      acc_a_r    <= 1'b0;
      acc_b_r    <= 1'b0;
      acc_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      wr_slot_r  <= wr_slot_nxt;
      in_base_r  <= in_base_nxt;
      row_slot_r <= row_slot_nxt;
      in_ahead_r <= in_ahead_nxt;
      hj_r       <= hj_nxt;
      lk_r       <= lk_nxt;
      vk_r       <= vk_nxt;
      acc_a_r    <= acc_a_nxt;
      acc_b_r    <= acc_b_nxt;
      acc_v_r    <= acc_v_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/separable_box_blur.sv =====
// Top level of the separable box blur: configuration registers, queue, engine, output register.
//
//   channel   direction  handshake                 payload
//   in_       request    in_valid / in_stall       in_func, in_argb
//   out_      result     out_valid / out_stall     out_argb, out_frame_last
//   apb       config     psel, penable, pwrite     paddr, pwdata, prdata
//
// For a request that yields a result, the vertical window is read from the
// line ring one line per cycle and the four channel means come from one shared
// divider. A pixel that closes a row also runs the horizontal pass first.
// Reset is synchronous and clears all control state; the line memories are
// not cleared and no clearing pass runs. Results wait in an output register,
// so a stall on the output holds back the engine and, through the two-entry
// queue, the input only once both are full.
`default_nettype none

module separable_box_blur #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_func,
  input  wire logic [sbb_pkg::ARGB_W-1:0]  in_argb,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sbb_pkg::ARGB_W-1:0]       out_argb,
  output logic                             out_frame_last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sbb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sbb_pkg::DATA_W-1:0]  pwdata,
  output logic [sbb_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import sbb_pkg::*;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [RADIUS_W-1:0] radius_r;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  cfg_t                cfg;

  logic   q_valid, q_pop;
  item_t  q_item;
  logic   res_valid, res_take;
  res_t   res;

  logic              out_valid_r;
  logic [ARGB_W-1:0] out_argb_r;
  logic              out_last_r;

  // The port never inserts wait states.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_RADIUS: prdata = DATA_W'(radius_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(640);
      height_r <= HEIGHT_W'(480);
      radius_r <= RADIUS_W'(4);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: height_r <= pwdata[HEIGHT_W-1:0];
        REG_RADIUS: radius_r <= pwdata[RADIUS_W-1:0];
        default:    ;
      endcase
    end
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign cfg.radius = radius_r;

  // Front end: takes requests into the queue so the requester can run ahead of the engine.
  sbb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_func),
    .in_argb  (in_argb),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back end: both blur passes and all position bookkeeping.
  sbb_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // The output register takes a new result whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_argb_r <= res.argb;
      out_last_r <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_argb       = out_argb_r;
  assign out_frame_last = out_last_r;

  // A result that the output register refused stays put in the engine.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(res.argb) && $stable(res.last))
    else $error("engine result changed while waiting");

  // A result handed over shows up on the output in the next cycle.
  a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid && (out_argb == $past(res.argb)))
    else $error("result lost on the way to the output");

  // An accepted request is visible to the engine in the next cycle.
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> q_valid)
    else $error("accepted request missing from the queue");

endmodule

`default_nettype wire

// ===== verif/separable_box_blur_tb.sv =====
// Self-checking testbench for the separable box blur: directed table, random frames, APB setup.
`default_nettype none

module separable_box_blur_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbb_pkg::*;

  localparam int LINE_MAX   = 1024;
  localparam int RING_DEPTH = 32;
  localparam int RAD_MAX    = 16;
  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 650;
  localparam int QUIET_AFTER = 560;

  typedef struct {
    logic [ARGB_W-1:0] argb;
    logic              last;
  } pix_t;

  typedef enum {ST_CFG, ST_PUSH, ST_DRAIN} step_kind_t;
  typedef enum {CHK_MODEL, CHK_PIXEL, CHK_NONE} chk_t;

  typedef struct {
    step_kind_t        kind;
    reg_idx_t          idx;
    logic [ARGB_W-1:0] val;
    chk_t              chk;
    pix_t              typed;
  } step_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_func = FUNC_PUSH;
  logic [ARGB_W-1:0]   in_argb = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ARGB_W-1:0]   out_argb;
  logic                out_frame_last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  separable_box_blur u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func), .in_argb(in_argb),
    .out_valid(out_valid), .out_stall(out_stall), .out_argb(out_argb),
    .out_frame_last(out_frame_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Blurred pixels the block still owes, oldest first.
  pix_t blur_expected[$];
  step_t directed_steps[$];
  int    errors = 0;
  bit    quiet = 1'b0;
  int    random_reqs = 0;

  // Shadow of the block: registers, current input row and the ring of
  // horizontally blurred lines, plus the input and output raster positions.
  logic [WIDTH_W-1:0]  sh_width = 11'd640;
  logic [HEIGHT_W-1:0] sh_height = 16'd480;
  logic [RADIUS_W-1:0] sh_radius = 5'd4;
  logic [ARGB_W-1:0]   row_pixels [LINE_MAX];
  logic [ARGB_W-1:0]   hblur_ring [RING_DEPTH][LINE_MAX];
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  int unsigned wr_slot = 0, in_base = 0, out_base = 0;
  bit          in_ahead = 1'b0;

  function automatic int unsigned eff_width();
    if (sh_width == 0) return 1;
    return (sh_width > LINE_MAX) ? LINE_MAX : sh_width;
  endfunction

  function automatic int unsigned eff_height();
    return (sh_height == 0) ? 1 : sh_height;
  endfunction

  function automatic int unsigned eff_radius();
    if (sh_radius == 0) return 1;
    return (sh_radius > RAD_MAX) ? RAD_MAX : sh_radius;
  endfunction

  // Per-channel truncating mean; an empty window gives zero.
  function automatic logic [ARGB_W-1:0] channel_mean(int unsigned s[4], int unsigned n);
    logic [ARGB_W-1:0] v;
    v = '0;
    if (n == 0) return v;
    for (int c = 0; c < 4; c++) v[8*c +: 8] = 8'((s[c] / n) & 8'hFF);
    return v;
  endfunction

  // True when the next step, even a drain, releases an output pixel.
  function automatic bit output_ready();
    int unsigned need;
    need = out_row + eff_radius() - 1;
    if (need > eff_height() - 1) need = eff_height() - 1;
    return in_ahead || (in_row > need);
  endfunction

  function automatic void blur_predict(input bit drain, input logic [ARGB_W-1:0] px,
                                       output bit has, output pix_t res);
    int unsigned w, h, r, lo, hi, col;
    int unsigned s[4];
    logic [ARGB_W-1:0] p;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    has = 1'b0;
    res.argb = '0;
    res.last = 1'b0;
    if (!drain) begin
      row_pixels[in_col % LINE_MAX] = px;
      in_col++;
      if (in_col >= w) begin
        // Row complete: horizontal pass into the next ring line.
        for (int unsigned j = 0; j < w; j++) begin
          lo = (j > r) ? j - r : 0;
          hi = (j + r < w) ? j + r : w;
          s = '{0, 0, 0, 0};
          for (int unsigned k = lo; k < hi; k++) begin
            p = row_pixels[k];
            for (int c = 0; c < 4; c++) s[c] += p[8*c +: 8];
          end
          hblur_ring[wr_slot % RING_DEPTH][j] = channel_mean(s, hi - lo);
        end
        wr_slot = (wr_slot + 1) % RING_DEPTH;
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          in_ahead = 1'b1;
          in_base = wr_slot;
        end
      end
    end
    if (!output_ready()) return;
    col = out_col % LINE_MAX;
    lo = (out_row > r) ? out_row - r : 0;
    hi = (out_row + r < h) ? out_row + r : h;
    s = '{0, 0, 0, 0};
    if (hi > lo) begin
      for (int unsigned k = lo; k < hi; k++) begin
        p = hblur_ring[(out_base + k) % RING_DEPTH][col];
        for (int c = 0; c < 4; c++) s[c] += p[8*c +: 8];
      end
      res.argb = channel_mean(s, hi - lo);
    end
    res.last = (out_row == h - 1) && (out_col == w - 1);
    has = 1'b1;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        out_row = 0;
        out_base = in_base;
        in_ahead = 1'b0;
      end
    end
  endfunction

  function automatic void add_step(step_kind_t kind, reg_idx_t idx, logic [ARGB_W-1:0] val,
                                   chk_t chk, logic [ARGB_W-1:0] e_argb, logic e_last);
    step_t st;
    st.kind = kind;
    st.idx = idx;
    st.val = val;
    st.chk = chk;
    st.typed.argb = e_argb;
    st.typed.last = e_last;
    directed_steps.push_back(st);
  endfunction

  // Sends one request and waits for it to be accepted. The caller either sends
  // the next request or lowers in_valid in the same time step.
  task automatic send_req(bit drain, logic [ARGB_W-1:0] px, chk_t chk, pix_t typed);
    bit   has;
    pix_t res;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= drain ? FUNC_DRAIN : FUNC_PUSH;
    in_argb  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    blur_predict(drain, px, has, res);
    if (chk == CHK_MODEL && has) blur_expected.push_back(res);
    else if (chk == CHK_PIXEL) blur_expected.push_back(typed);
  endtask

  task automatic send_model(bit drain, logic [ARGB_W-1:0] px);
    pix_t none;
    none.argb = '0;
    none.last = 1'b0;
    send_req(drain, px, CHK_MODEL, none);
    random_reqs++;
    if (random_reqs > QUIET_AFTER) quiet = 1'b1;
  endtask

  // Waits for every owed pixel, then for a horizontal pass that may still run.
  task automatic settle();
    in_valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (11 * eff_width() + 3 * eff_radius() + 40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:  sh_width  = val[WIDTH_W-1:0];
      REG_HEIGHT: sh_height = val[HEIGHT_W-1:0];
      REG_RADIUS: sh_radius = val[RADIUS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [ARGB_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One frame of pixels with the odd drain mixed in.
  task automatic push_frame();
    int unsigned n;
    n = eff_width() * eff_height();
    for (int unsigned i = 0; i < n; i++) begin
      if (!quiet && $urandom_range(0, 9) == 0) send_model(1'b1, $urandom);
      send_model(1'b0, rand_pixel());
    end
  endtask

  task automatic drain_all();
    while (output_ready()) send_model(1'b1, $urandom);
  endtask

  // Result side: check each accepted pixel, then choose the next stall.
  int stall_left = 0;
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("separable_box_blur_tb NOT OK");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (blur_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel argb=%h last=%b", $time, out_argb, out_frame_last);
        end else begin
          if (out_argb !== blur_expected[0].argb) begin
            errors++;
            $display("%0t: argb expected %h actual %h", $time, blur_expected[0].argb, out_argb);
          end
          if (out_frame_last !== blur_expected[0].last) begin
            errors++;
            $display("%0t: frame_last expected %b actual %b", $time,
                     blur_expected[0].last, out_frame_last);
          end
          void'(blur_expected.pop_front());
        end
      end
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int frames;
    int phase;
    logic [DATA_W-1:0] w, h, r;

    // Directed part. A drain right after reset has nothing to release. A 1x1
    // frame returns its own pixel as the last one. The 3x2 frame with the
    // largest radius clips every window at the image edges.
    add_step(ST_DRAIN, REG_WIDTH, 32'h0, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_CFG, REG_WIDTH, 32'd1, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_CFG, REG_HEIGHT, 32'd1, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_CFG, REG_RADIUS, 32'd1, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_PUSH, REG_WIDTH, 32'h0000_0000, CHK_PIXEL, 32'h0000_0000, 1'b1);
    add_step(ST_PUSH, REG_WIDTH, 32'hFFFF_FFFF, CHK_PIXEL, 32'hFFFF_FFFF, 1'b1);
    add_step(ST_PUSH, REG_WIDTH, 32'hA5A5_5A5A, CHK_PIXEL, 32'hA5A5_5A5A, 1'b1);
    add_step(ST_DRAIN, REG_WIDTH, 32'hFFFF_FFFF, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_CFG, REG_WIDTH, 32'd3, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_CFG, REG_HEIGHT, 32'd2, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_CFG, REG_RADIUS, 32'd16, CHK_NONE, 32'h0, 1'b0);
    add_step(ST_PUSH, REG_WIDTH, 32'hFFFF_FFFF, CHK_MODEL, 32'h0, 1'b0);
    add_step(ST_PUSH, REG_WIDTH, 32'h0000_0000, CHK_MODEL, 32'h0, 1'b0);
    add_step(ST_PUSH, REG_WIDTH, 32'h8040_2010, CHK_MODEL, 32'h0, 1'b0);
    add_step(ST_PUSH, REG_WIDTH, 32'h0102_0304, CHK_MODEL, 32'h0, 1'b0);
    add_step(ST_PUSH, REG_WIDTH, 32'hFF00_FF00, CHK_MODEL, 32'h0, 1'b0);
    add_step(ST_PUSH, REG_WIDTH, 32'h00FF_00FF, CHK_MODEL, 32'h0, 1'b0);
    for (int i = 0; i < 5; i++) add_step(ST_DRAIN, REG_WIDTH, 32'h5A5A_A5A5, CHK_MODEL,
                                          32'h0, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ST_CFG) begin
        settle();
        write_reg(directed_steps[i].idx, directed_steps[i].val);
      end else begin
        send_req(directed_steps[i].kind == ST_DRAIN, directed_steps[i].val,
                 directed_steps[i].chk, directed_steps[i].typed);
      end
    end

    // Random phases: each writes all three registers while idle, then runs a
    // few frames, sometimes back to back, and drains what is left.
    phase = 0;
    while (random_reqs < RANDOM_REQS) begin
      settle();
      if (phase == 2) begin
        // One long row with the radius clamped from an over-range value.
        w = 32'd200;
        h = 32'd1;
        r = 32'd31;
      end else begin
        case ($urandom_range(0, 9))
          0:       w = 32'd0;
          1, 2:    w = $urandom_range(9, 40);
          default: w = $urandom_range(1, 8);
        endcase
        h = $urandom_range(0, 6);
        r = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      end
      if (phase == 1) write_reg(REG_HEIGHT, 32'd65535);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_RADIUS, r);
      frames = (phase == 2) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        // Starting the next frame before the last one has drained: release all pending
        // pixels, or just one, first so the older frame is done before the new one ends.
        if (f > 0) begin
          if ($urandom_range(0, 1) == 0) drain_all();
          else if (output_ready()) send_model(1'b1, $urandom);
        end
        push_frame();
      end
      drain_all();
      phase++;
    end

    in_valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (11 * eff_width() + 3 * eff_radius() + 40) @(posedge clk);
    if (errors == 0 && blur_expected.size() == 0) begin
      $display("separable_box_blur_tb OK");
    end else begin
      $display("separable_box_blur_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
